FILE: rtl/btrg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btrg_pkg
// Shared types, codes and helpers of the bitmap text row generator.
// ----------------------------------------------------------------------------
package btrg_pkg;

    localparam int GLYPH_MEM_DEPTH_DEF = 4096;
    localparam int MAX_GLYPH_ROWS_DEF  = 16;

    localparam logic [12:0] COORD_MAX = 13'h1FFF;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_DRAW    = 2'd1;
    localparam logic [1:0] CMD_SET_PEN = 2'd2;

    localparam logic [1:0] REG_FONT_MODE     = 2'd0;
    localparam logic [1:0] REG_DRAW_COLOR    = 2'd1;
    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd3;

    localparam logic [1:0] MODE_H14 = 2'd1;
    localparam logic [1:0] MODE_H16 = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam logic [1:0]  FONT_MODE_RST     = 2'd0;
    localparam logic [31:0] DRAW_COLOR_RST    = 32'hFFFF_FFFF;
    localparam logic [12:0] WINDOW_WIDTH_RST  = 13'd1920;
    localparam logic [12:0] WINDOW_HEIGHT_RST = 13'd1080;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] glyph_addr;
        logic [7:0]  glyph_byte;
        logic [7:0]  char_code;
        logic        string_end;
        logic [12:0] pos_x;
        logic [12:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic [12:0] row_x;
        logic [12:0] row_y;
        logic [7:0]  row_mask;
        logic [31:0] pixel_color;
        logic        last_row;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } state_t;

    function automatic logic [4:0] mode_height(input logic [1:0] mode);
        logic [4:0] h;
        case (mode)
            MODE_H14: h = 5'd14;
            MODE_H16: h = 5'd16;
            default:  h = 5'd8;
        endcase
        return h;
    endfunction

    function automatic logic [12:0] sat_coord(input logic [13:0] v);
        return v[13] ? COORD_MAX : v[12:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/btrg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btrg_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bitmap_text_row_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_text_row_generator_top
// Character generator: glyph RAM loader, pen tracking and per-row mask output.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (s_valid/s_ready, s_data) carry one command each: glyph
//   byte write, character draw or pen set. Result requests (m_valid/m_ready,
//   m_data) carry one glyph row each: position, clipped 8-pixel mask, colour
//   and a last-row flag.
//   Writes, pen sets and newlines do not hold the input. A drawn character
//   holds the input until its last row is read (8, 14 or 16 rows for the
//   8x8, 8x14 and 8x16 modes), through the single read port of the glyph
//   RAM, one row per cycle while the output does not stall.
//   With m_ready low the output register and a one-entry skid buffer hold
//   results and row reads pause; nothing is dropped.
//   Reset clears pen, line start and line y to zero and loads the register
//   defaults; glyph RAM contents are kept and must be written before use.
//   Configuration writes take effect at once; the user must apply them while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module bitmap_text_row_generator_top #(
    parameter int GLYPH_MEM_DEPTH = btrg_pkg::GLYPH_MEM_DEPTH_DEF,
    parameter int MAX_GLYPH_ROWS  = btrg_pkg::MAX_GLYPH_ROWS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire btrg_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output btrg_pkg::out_item_t       m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_wdata
);

    import btrg_pkg::*;

    localparam int AW = $clog2(GLYPH_MEM_DEPTH);
    localparam int RW = $clog2(MAX_GLYPH_ROWS);
    localparam logic [13:0] DepthLimit = 14'(GLYPH_MEM_DEPTH);
    localparam logic [4:0]  MaxRowsM1  = 5'(MAX_GLYPH_ROWS - 1);

    logic [1:0]  font_mode_reg;
    logic [31:0] draw_color_reg;
    logic [12:0] window_width_reg;
    logic [12:0] window_height_reg;

    logic [12:0] pen_x_reg, pen_x_next;
    logic [12:0] line_start_x_reg;
    logic [12:0] line_y_reg, line_y_next;

    state_t state_reg, state_next;
    logic   issue;
    logic   s_fire;
    logic   draw_start;

    logic [12:0]   draw_x_reg;
    logic [12:0]   draw_y_reg;
    logic [7:0]    col_mask_reg, col_mask_next;
    logic [11:0]   base_addr_reg;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_last_reg;

    logic      pend_valid_reg;
    logic      pend_clip_reg;
    out_item_t pend_meta_reg;
    out_item_t pend_item;

    logic      out_valid_reg;
    out_item_t out_reg;
    logic      skid_valid_reg;
    out_item_t skid_reg;
    logic      out_free;
    logic      can_issue;

    logic [4:0]  height;
    logic [4:0]  rows_m1;
    logic [11:0] rd_addr;
    logic [12:0] rd_addr_ext;
    logic [12:0] wr_addr_ext;
    logic        rd_in_range;
    logic        wr_in_range;
    logic [13:0] row_y_wide;
    logic        row_clip;
    logic [7:0]  rd_data;
    logic        ram_we;

    assign height  = mode_height(font_mode_reg);
    assign rows_m1 = ((height - 5'd1) < MaxRowsM1) ? (height - 5'd1) : MaxRowsM1;

    assign out_free  = !out_valid_reg || m_ready;
    assign can_issue = !skid_valid_reg && !(pend_valid_reg && !out_free);
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        issue      = 1'b0;
        draw_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_data.cmd == CMD_DRAW && s_data.char_code != NEWLINE_CODE) begin
                    draw_start = 1'b1;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                issue = can_issue;
                if (can_issue && row_reg == row_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign rd_addr     = base_addr_reg + 12'(row_reg);
    assign rd_addr_ext = {1'b0, rd_addr};
    assign wr_addr_ext = {1'b0, s_data.glyph_addr};
    assign rd_in_range = {2'b00, rd_addr} < DepthLimit;
    assign wr_in_range = {2'b00, s_data.glyph_addr} < DepthLimit;
    assign ram_we      = s_fire && s_data.cmd == CMD_WRITE && wr_in_range;

    btrg_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_MEM_DEPTH)
    ) u_glyph_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr_ext[AW-1:0]),
        .wr_data (s_data.glyph_byte),
        .rd_en   (issue),
        .rd_addr (rd_addr_ext[AW-1:0]),
        .rd_data (rd_data)
    );

    assign row_y_wide = {1'b0, draw_y_reg} + 14'(row_reg);
    assign row_clip   = (row_y_wide >= {1'b0, window_height_reg}) || !rd_in_range;

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            col_mask_next[7 - c] = ({1'b0, pen_x_reg} + 14'(c)) < {1'b0, window_width_reg};
        end
    end

    always_comb begin
        pen_x_next  = pen_x_reg;
        line_y_next = line_y_reg;
        if (s_fire && s_data.cmd == CMD_DRAW) begin
            if (s_data.char_code == NEWLINE_CODE) begin
                pen_x_next  = line_start_x_reg;
                line_y_next = sat_coord({1'b0, line_y_reg} + {9'd0, height} + 14'd1);
            end else begin
                pen_x_next = sat_coord({1'b0, pen_x_reg} + 14'd8);
            end
            if (s_data.string_end) begin
                pen_x_next = line_start_x_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg        <= '0;
            line_start_x_reg <= '0;
            line_y_reg       <= '0;
        end else if (s_fire && s_data.cmd == CMD_SET_PEN) begin
            pen_x_reg        <= s_data.pos_x;
            line_start_x_reg <= s_data.pos_x;
            line_y_reg       <= s_data.pos_y;
        end else begin
            pen_x_reg  <= pen_x_next;
            line_y_reg <= line_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_mode_reg     <= FONT_MODE_RST;
            draw_color_reg    <= DRAW_COLOR_RST;
            window_width_reg  <= WINDOW_WIDTH_RST;
            window_height_reg <= WINDOW_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FONT_MODE:     font_mode_reg     <= cfg_wdata[1:0];
                REG_DRAW_COLOR:    draw_color_reg    <= cfg_wdata;
                REG_WINDOW_WIDTH:  window_width_reg  <= cfg_wdata[12:0];
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && draw_start) begin
            draw_x_reg    <= pen_x_reg;
            draw_y_reg    <= line_y_reg;
            col_mask_reg  <= col_mask_next;
            base_addr_reg <= 12'(16'(s_data.char_code) * 16'(height));
            row_reg       <= '0;
            row_last_reg  <= rows_m1[RW-1:0];
        end else if (issue) begin
            row_reg <= row_reg + 1'b1;
        end
        if (issue) begin
            pend_meta_reg.row_x       <= draw_x_reg;
            pend_meta_reg.row_y       <= sat_coord(row_y_wide);
            pend_meta_reg.row_mask    <= col_mask_reg;
            pend_meta_reg.pixel_color <= draw_color_reg;
            pend_meta_reg.last_row    <= (row_reg == row_last_reg);
            pend_clip_reg             <= row_clip;
        end
    end

    always_comb begin
        pend_item          = pend_meta_reg;
        pend_item.row_mask = pend_clip_reg ? 8'd0 : (rd_data & pend_meta_reg.row_mask);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= issue;
            if (out_free) begin
                out_valid_reg  <= skid_valid_reg || pend_valid_reg;
                skid_valid_reg <= skid_valid_reg && pend_valid_reg;
            end else if (pend_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : pend_item;
            if (skid_valid_reg) begin
                skid_reg <= pend_item;
            end
        end else if (pend_valid_reg) begin
            skid_reg <= pend_item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

FILE: rtl/btrg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btrg_checker
// Port-level checks of the bitmap text row generator, bound to the top level.
// ----------------------------------------------------------------------------
module btrg_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire btrg_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire btrg_pkg::out_item_t m_data
);

    import btrg_pkg::*;

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result request changed");

    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd == CMD_DRAW && s_data.char_code != NEWLINE_CODE
        |=> !s_ready)
        else $error("input not held during character draw");

    a_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.cmd != CMD_DRAW || s_data.char_code == NEWLINE_CODE)
        |=> s_ready)
        else $error("single-cycle request blocked the input");

endmodule

bind bitmap_text_row_generator_top btrg_checker u_btrg_checker (.*);
`default_nettype wire
